/* design/grdp_pkg.sv */
// Shared constants, types and address helpers for the grid path search core.
// Used by every design file except grdp_ram through scoped names; depends on nothing.
package grdp_pkg;

   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLS    = 64;
   localparam int RUN_SLOTS   = 11;
   localparam int QUEUE_DEPTH = 65536;

   localparam int COST_W      = 22;
   localparam int CFG_W       = 4;
   localparam int CELL_COST_W = 4;
   localparam int DIR_W       = 2;

   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RUN_W  = $clog2(RUN_SLOTS);
   localparam int ROWC_W = $clog2(MAX_ROWS + 1);
   localparam int COLC_W = $clog2(MAX_COLS + 1);

   localparam int CELL_DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int CELL_W      = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
   localparam int STATE_COUNT = CELL_DEPTH * 4 * RUN_SLOTS;
   localparam int STATE_W     = $clog2(STATE_COUNT);
   localparam int QUEUE_W     = $clog2(QUEUE_DEPTH);
   localparam int LEN_W       = QUEUE_W + 1;

   localparam logic [COST_W-1:0] COST_INF = 22'h3FFFFF;
   localparam logic [COST_W-1:0] COST_SAT = 22'h3FFFFE;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RUN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RUN = 2'd1;
   localparam logic [CFG_W-1:0] MIN_RUN_RST = 4'd4;
   localparam logic [CFG_W-1:0] MAX_RUN_RST = 4'd10;
   localparam logic [CFG_W-1:0] RUN_TOP     = CFG_W'(RUN_SLOTS - 1);

   localparam logic [DIR_W-1:0] DIR_NORTH = 2'd0;
   localparam logic [DIR_W-1:0] DIR_EAST  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd2;
   localparam logic [DIR_W-1:0] DIR_WEST  = 2'd3;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [DIR_W-1:0]  dir;
      logic [RUN_W-1:0]  run;
   } key_type;

   localparam int KEY_W = $bits(key_type);

   typedef struct packed {
      logic                   en;
      logic [CELL_W-1:0]      addr;
      logic [CELL_COST_W-1:0] cost;
   } cell_wr_type;

   typedef struct packed {
      logic              start;
      logic [ROWC_W-1:0] rows;
      logic [COLC_W-1:0] cols;
      logic [CFG_W-1:0]  min_run;
      logic [CFG_W-1:0]  max_run;
   } srch_cmd_type;

   typedef struct packed {
      logic              done;
      logic [COST_W-1:0] min_cost;
      logic              reachable;
      logic              overflow;
   } srch_res_type;

   function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      cell_addr = CELL_W'(32'(r) * MAX_COLS + 32'(c));
   endfunction

   function automatic logic [STATE_W-1:0] state_addr(input logic [ROW_W-1:0] r,
                                                     input logic [COL_W-1:0] c,
                                                     input logic [DIR_W-1:0] d,
                                                     input logic [RUN_W-1:0] k);
      state_addr = STATE_W'(((32'(r) * MAX_COLS + 32'(c)) * 4 + 32'(d)) * RUN_SLOTS
                            + 32'(k));
   endfunction

endpackage

/* design/grdp_ifs.sv */
// Handshake channel interfaces: cell input, result output, register write.
// Depends on grdp_pkg for field widths.
interface grdp_req_if;
   logic                             valid;
   logic                             ready;
   logic [grdp_pkg::CELL_COST_W-1:0] cell_cost;
   logic                             row_end;
   logic                             grid_end;
   modport source (output valid, output cell_cost, output row_end, output grid_end,
                   input ready);
   modport sink (input valid, input cell_cost, input row_end, input grid_end,
                 output ready);
endinterface

interface grdp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [grdp_pkg::COST_W-1:0] min_cost;
   logic                        reachable;
   logic                        queue_overflow;
   modport source (output valid, output min_cost, output reachable,
                   output queue_overflow, input ready);
   modport sink (input valid, input min_cost, input reachable, input queue_overflow,
                 output ready);
endinterface

interface grdp_csr_if;
   logic                           valid;
   logic                           ready;
   logic [grdp_pkg::CSR_IDX_W-1:0] index;
   logic [grdp_pkg::CFG_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* design/grdp_ram.sv */
// Generic simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module grdp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/grdp_search.sv */
// Search engine: cell cost, best cost and heap memories plus the sequencer that
// clears, runs the priority-queue search and reduces the target. Uses grdp_pkg, grdp_ram.
module grdp_search (
   input  logic                   clock,
   input  logic                   reset,
   input  grdp_pkg::cell_wr_type  cell_wr,
   input  grdp_pkg::srch_cmd_type cmd,
   input  logic                   res_ready,
   output grdp_pkg::srch_res_type res
);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_CLEAR    = 5'd1;
   localparam logic [4:0] S_INIT0    = 5'd2;
   localparam logic [4:0] S_MAIN     = 5'd3;
   localparam logic [4:0] S_POP0     = 5'd4;
   localparam logic [4:0] S_POP1     = 5'd5;
   localparam logic [4:0] S_POP2     = 5'd6;
   localparam logic [4:0] S_SIFT     = 5'd7;
   localparam logic [4:0] S_SIFTL    = 5'd8;
   localparam logic [4:0] S_SIFTR    = 5'd9;
   localparam logic [4:0] S_SIFTC    = 5'd10;
   localparam logic [4:0] S_EXP_RD   = 5'd11;
   localparam logic [4:0] S_EXP_CHK  = 5'd12;
   localparam logic [4:0] S_NB       = 5'd13;
   localparam logic [4:0] S_NB_CHK   = 5'd14;
   localparam logic [4:0] S_PUSH     = 5'd15;
   localparam logic [4:0] S_PUSH_UP  = 5'd16;
   localparam logic [4:0] S_PUSH_CMP = 5'd17;
   localparam logic [4:0] S_FIN      = 5'd18;
   localparam logic [4:0] S_FIN_ACC  = 5'd19;
   localparam logic [4:0] S_DONE     = 5'd20;

   localparam logic [1:0] RET_INIT1 = 2'd0;
   localparam logic [1:0] RET_MAIN  = 2'd1;
   localparam logic [1:0] RET_NB    = 2'd2;

   localparam int LCH_W = grdp_pkg::QUEUE_W + 2;

   logic [4:0]                       state_ff, state_in;
   logic [grdp_pkg::LEN_W-1:0]       len_ff, len_in;
   logic [grdp_pkg::QUEUE_W-1:0]     idx_ff, idx_in;
   logic [grdp_pkg::QUEUE_W-1:0]     cidx_ff, cidx_in;
   grdp_pkg::key_type                top_ff, top_in;
   grdp_pkg::key_type                last_ff, last_in;
   grdp_pkg::key_type                cand_ff, cand_in;
   grdp_pkg::key_type                push_key_ff, push_key_in;
   grdp_pkg::key_type                nb_ff, nb_in;
   logic [1:0]                       ret_ff, ret_in;
   logic [1:0]                       turn_ff, turn_in;
   logic                             ovf_ff, ovf_in;
   logic [grdp_pkg::STATE_W-1:0]     clr_ff, clr_in;
   logic [grdp_pkg::DIR_W-1:0]       fin_dir_ff, fin_dir_in;
   logic [grdp_pkg::CFG_W-1:0]       fin_run_ff, fin_run_in;
   logic [grdp_pkg::COST_W-1:0]      fin_min_ff, fin_min_in;
   grdp_pkg::srch_cmd_type           cmd_ff, cmd_in;

   logic                             hp_we, hp_re;
   logic [grdp_pkg::QUEUE_W-1:0]     hp_waddr, hp_raddr;
   grdp_pkg::key_type                hp_wdata;
   logic [grdp_pkg::KEY_W-1:0]       hp_rbits;
   grdp_pkg::key_type                hp_rdata;

   logic                             bc_we, bc_re;
   logic [grdp_pkg::STATE_W-1:0]     bc_waddr, bc_raddr;
   logic [grdp_pkg::COST_W-1:0]      bc_wdata, bc_rdata;

   logic                             cc_re;
   logic [grdp_pkg::CELL_W-1:0]      cc_raddr;
   logic [grdp_pkg::CELL_COST_W-1:0] cc_rdata;

   logic [LCH_W-1:0]                 lch, rch, len_x;
   logic [grdp_pkg::QUEUE_W-1:0]     par_idx;
   logic [grdp_pkg::DIR_W-1:0]       nd;
   logic                             straight, nb_allowed, nb_inside;
   logic [grdp_pkg::ROW_W-1:0]       nr;
   logic [grdp_pkg::COL_W-1:0]       nc;
   logic [grdp_pkg::RUN_W-1:0]       nk;
   logic [grdp_pkg::COST_W:0]        sum;
   logic [grdp_pkg::COST_W-1:0]      w;
   logic [grdp_pkg::ROW_W-1:0]       tgt_row;
   logic [grdp_pkg::COL_W-1:0]       tgt_col;
   logic                             fin_reach;

   grdp_ram #(.WIDTH(grdp_pkg::CELL_COST_W), .DEPTH(grdp_pkg::CELL_DEPTH)) u_cell_ram (
      .clock(clock), .wr_en(cell_wr.en), .wr_addr(cell_wr.addr), .wr_data(cell_wr.cost),
      .rd_en(cc_re), .rd_addr(cc_raddr), .rd_data(cc_rdata));

   grdp_ram #(.WIDTH(grdp_pkg::COST_W), .DEPTH(grdp_pkg::STATE_COUNT)) u_best_ram (
      .clock(clock), .wr_en(bc_we), .wr_addr(bc_waddr), .wr_data(bc_wdata),
      .rd_en(bc_re), .rd_addr(bc_raddr), .rd_data(bc_rdata));

   grdp_ram #(.WIDTH(grdp_pkg::KEY_W), .DEPTH(grdp_pkg::QUEUE_DEPTH)) u_heap_ram (
      .clock(clock), .wr_en(hp_we), .wr_addr(hp_waddr), .wr_data(hp_wdata),
      .rd_en(hp_re), .rd_addr(hp_raddr), .rd_data(hp_rbits));

   assign hp_rdata = grdp_pkg::key_type'(hp_rbits);

   assign lch     = {1'b0, idx_ff, 1'b1};
   assign rch     = lch + LCH_W'(1);
   assign len_x   = LCH_W'(len_ff);
   assign par_idx = grdp_pkg::QUEUE_W'((idx_ff - grdp_pkg::QUEUE_W'(1)) >> 1);

   assign nd       = top_ff.dir + turn_ff + 2'd3;
   assign straight = (turn_ff == 2'd1);
   assign nb_allowed = straight ? (grdp_pkg::CFG_W'(top_ff.run) < cmd_ff.max_run)
                                : (grdp_pkg::CFG_W'(top_ff.run) >= cmd_ff.min_run);

   always_comb begin
      nb_inside = 1'b1;
      nr        = top_ff.row;
      nc        = top_ff.col;
      case (nd)
         grdp_pkg::DIR_NORTH: begin
            nb_inside = (top_ff.row != '0);
            nr        = top_ff.row - grdp_pkg::ROW_W'(1);
         end
         grdp_pkg::DIR_EAST: begin
            nb_inside = (grdp_pkg::COLC_W'(top_ff.col) + grdp_pkg::COLC_W'(1) < cmd_ff.cols);
            nc        = top_ff.col + grdp_pkg::COL_W'(1);
         end
         grdp_pkg::DIR_SOUTH: begin
            nb_inside = (grdp_pkg::ROWC_W'(top_ff.row) + grdp_pkg::ROWC_W'(1) < cmd_ff.rows);
            nr        = top_ff.row + grdp_pkg::ROW_W'(1);
         end
         default: begin
            nb_inside = (top_ff.col != '0);
            nc        = top_ff.col - grdp_pkg::COL_W'(1);
         end
      endcase
   end

   assign nk  = straight ? top_ff.run + grdp_pkg::RUN_W'(1) : grdp_pkg::RUN_W'(1);
   assign sum = {1'b0, top_ff.cost} + (grdp_pkg::COST_W + 1)'(cc_rdata);
   assign w   = (sum > (grdp_pkg::COST_W + 1)'(grdp_pkg::COST_SAT)) ? grdp_pkg::COST_SAT
                                                                   : sum[grdp_pkg::COST_W-1:0];

   assign tgt_row = grdp_pkg::ROW_W'(cmd_ff.rows - grdp_pkg::ROWC_W'(1));
   assign tgt_col = grdp_pkg::COL_W'(cmd_ff.cols - grdp_pkg::COLC_W'(1));
   assign fin_reach = (fin_min_ff < grdp_pkg::COST_INF);

   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      cidx_in     = cidx_ff;
      top_in      = top_ff;
      last_in     = last_ff;
      cand_in     = cand_ff;
      push_key_in = push_key_ff;
      nb_in       = nb_ff;
      ret_in      = ret_ff;
      turn_in     = turn_ff;
      ovf_in      = ovf_ff;
      clr_in      = clr_ff;
      fin_dir_in  = fin_dir_ff;
      fin_run_in  = fin_run_ff;
      fin_min_in  = fin_min_ff;
      cmd_in      = cmd_ff;

      hp_we    = 1'b0;
      hp_waddr = idx_ff;
      hp_wdata = last_ff;
      hp_re    = 1'b0;
      hp_raddr = '0;
      bc_we    = 1'b0;
      bc_waddr = clr_ff;
      bc_wdata = grdp_pkg::COST_INF;
      bc_re    = 1'b0;
      bc_raddr = grdp_pkg::state_addr(top_ff.row, top_ff.col, top_ff.dir, top_ff.run);
      cc_re    = 1'b0;
      cc_raddr = grdp_pkg::cell_addr(nr, nc);
      res      = '0;

      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               cmd_in     = cmd;
               clr_in     = '0;
               len_in     = '0;
               ovf_in     = 1'b0;
               fin_min_in = grdp_pkg::COST_INF;
               state_in   = S_CLEAR;
            end
         end
         S_CLEAR: begin
            bc_we  = 1'b1;
            clr_in = clr_ff + grdp_pkg::STATE_W'(1);
            if (clr_ff == grdp_pkg::STATE_W'(grdp_pkg::STATE_COUNT - 1)) begin
               state_in = S_INIT0;
            end
         end
         S_INIT0: begin
            push_key_in     = '0;
            push_key_in.dir = grdp_pkg::DIR_EAST;
            ret_in          = RET_INIT1;
            state_in        = S_PUSH;
         end
         S_MAIN: begin
            if (len_ff != '0 && !ovf_ff) begin
               state_in = S_POP0;
            end else begin
               fin_dir_in = '0;
               fin_run_in = cmd_ff.min_run;
               state_in   = S_FIN;
            end
         end
         S_POP0: begin
            hp_re    = 1'b1;
            hp_raddr = '0;
            state_in = S_POP1;
         end
         S_POP1: begin
            top_in   = hp_rdata;
            hp_re    = 1'b1;
            hp_raddr = grdp_pkg::QUEUE_W'(len_ff - grdp_pkg::LEN_W'(1));
            len_in   = len_ff - grdp_pkg::LEN_W'(1);
            state_in = S_POP2;
         end
         S_POP2: begin
            last_in  = hp_rdata;
            idx_in   = '0;
            state_in = S_SIFT;
         end
         S_SIFT: begin
            if (lch >= len_x) begin
               hp_we    = (len_ff != '0);
               state_in = S_EXP_RD;
            end else begin
               hp_re    = 1'b1;
               hp_raddr = grdp_pkg::QUEUE_W'(lch);
               state_in = S_SIFTL;
            end
         end
         S_SIFTL: begin
            cand_in = hp_rdata;
            cidx_in = grdp_pkg::QUEUE_W'(lch);
            if (rch < len_x) begin
               hp_re    = 1'b1;
               hp_raddr = grdp_pkg::QUEUE_W'(rch);
               state_in = S_SIFTR;
            end else begin
               state_in = S_SIFTC;
            end
         end
         S_SIFTR: begin
            if (hp_rdata < cand_ff) begin
               cand_in = hp_rdata;
               cidx_in = grdp_pkg::QUEUE_W'(rch);
            end
            state_in = S_SIFTC;
         end
         S_SIFTC: begin
            hp_we = 1'b1;
            if (cand_ff >= last_ff) begin
               state_in = S_EXP_RD;
            end else begin
               hp_wdata = cand_ff;
               idx_in   = cidx_ff;
               state_in = S_SIFT;
            end
         end
         S_EXP_RD: begin
            bc_re    = 1'b1;
            state_in = S_EXP_CHK;
         end
         S_EXP_CHK: begin
            if (top_ff.cost > bc_rdata) begin
               state_in = S_MAIN;
            end else begin
               turn_in  = '0;
               state_in = S_NB;
            end
         end
         S_NB: begin
            if (nb_allowed && nb_inside) begin
               cc_re    = 1'b1;
               bc_re    = 1'b1;
               bc_raddr = grdp_pkg::state_addr(nr, nc, nd, nk);
               nb_in.row = nr;
               nb_in.col = nc;
               nb_in.dir = nd;
               nb_in.run = nk;
               state_in = S_NB_CHK;
            end else if (turn_ff == 2'd2) begin
               state_in = S_MAIN;
            end else begin
               turn_in = turn_ff + 2'd1;
            end
         end
         S_NB_CHK: begin
            if (w < bc_rdata) begin
               bc_we            = 1'b1;
               bc_waddr         = grdp_pkg::state_addr(nb_ff.row, nb_ff.col, nb_ff.dir,
                                                       nb_ff.run);
               bc_wdata         = w;
               push_key_in      = nb_ff;
               push_key_in.cost = w;
               ret_in           = RET_NB;
               state_in         = S_PUSH;
            end else if (turn_ff == 2'd2) begin
               state_in = S_MAIN;
            end else begin
               turn_in  = turn_ff + 2'd1;
               state_in = S_NB;
            end
         end
         S_PUSH: begin
            if (len_ff == grdp_pkg::LEN_W'(grdp_pkg::QUEUE_DEPTH)) begin
               ovf_in   = 1'b1;
               state_in = S_MAIN;
            end else begin
               idx_in   = grdp_pkg::QUEUE_W'(len_ff);
               len_in   = len_ff + grdp_pkg::LEN_W'(1);
               state_in = S_PUSH_UP;
            end
         end
         S_PUSH_UP: begin
            if (idx_ff == '0) begin
               hp_we    = 1'b1;
               hp_wdata = push_key_ff;
               case (ret_ff)
                  RET_INIT1: begin
                     push_key_in     = '0;
                     push_key_in.dir = grdp_pkg::DIR_SOUTH;
                     ret_in          = RET_MAIN;
                     state_in        = S_PUSH;
                  end
                  RET_MAIN: begin
                     state_in = S_MAIN;
                  end
                  default: begin
                     if (turn_ff == 2'd2) begin
                        state_in = S_MAIN;
                     end else begin
                        turn_in  = turn_ff + 2'd1;
                        state_in = S_NB;
                     end
                  end
               endcase
            end else begin
               hp_re    = 1'b1;
               hp_raddr = par_idx;
               state_in = S_PUSH_CMP;
            end
         end
         S_PUSH_CMP: begin
            hp_we = 1'b1;
            if (hp_rdata <= push_key_ff) begin
               hp_wdata = push_key_ff;
               idx_in   = '0;
               state_in = S_PUSH_UP;
               // finish here as the root branch would, without a second write
               if (ret_ff == RET_INIT1) begin
                  push_key_in     = '0;
                  push_key_in.dir = grdp_pkg::DIR_SOUTH;
                  ret_in          = RET_MAIN;
                  state_in        = S_PUSH;
               end else if (ret_ff == RET_MAIN) begin
                  state_in = S_MAIN;
               end else if (turn_ff == 2'd2) begin
                  state_in = S_MAIN;
               end else begin
                  turn_in  = turn_ff + 2'd1;
                  state_in = S_NB;
               end
            end else begin
               hp_wdata = hp_rdata;
               idx_in   = par_idx;
               state_in = S_PUSH_UP;
            end
         end
         S_FIN: begin
            if (fin_run_ff > cmd_ff.max_run) begin
               if (fin_dir_ff == grdp_pkg::DIR_WEST) begin
                  state_in = S_DONE;
               end else begin
                  fin_dir_in = fin_dir_ff + 2'd1;
                  fin_run_in = cmd_ff.min_run;
               end
            end else begin
               bc_re    = 1'b1;
               bc_raddr = grdp_pkg::state_addr(tgt_row, tgt_col, fin_dir_ff,
                                               grdp_pkg::RUN_W'(fin_run_ff));
               state_in = S_FIN_ACC;
            end
         end
         S_FIN_ACC: begin
            if (bc_rdata < fin_min_ff) begin
               fin_min_in = bc_rdata;
            end
            fin_run_in = fin_run_ff + grdp_pkg::CFG_W'(1);
            state_in   = S_FIN;
         end
         S_DONE: begin
            if (res_ready) begin
               res.done      = 1'b1;
               res.min_cost  = fin_reach ? fin_min_ff : '0;
               res.reachable = fin_reach;
               res.overflow  = ovf_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cidx_ff     <= cidx_in;
      top_ff      <= top_in;
      last_ff     <= last_in;
      cand_ff     <= cand_in;
      push_key_ff <= push_key_in;
      nb_ff       <= nb_in;
      ret_ff      <= ret_in;
      turn_ff     <= turn_in;
      clr_ff      <= clr_in;
      fin_dir_ff  <= fin_dir_in;
      fin_run_ff  <= fin_run_in;
      fin_min_ff  <= fin_min_in;
      cmd_ff      <= cmd_in;
   end

endmodule

/* design/grid_path_run_limited_dijkstra_core.sv */
// Top level: channel handshakes, grid load counters, run-limit registers, result register.
// Depends on grdp_pkg, grdp_ifs and grdp_search.

// Cells load one per cycle in row-major order while req_bus.ready is high. The
// item with grid_end set starts the search and drops req_bus.ready until the
// result is in the output register: first a sweep of the best-cost memory, one
// entry per cycle over all 180224 states, then the search, in which each pop
// sifts the heap down and each push sifts it up one level at a time through the
// read and write ports of the heap memory, then a scan of up to 44 target states.
// The result waits in rsp_bus until taken; loading of the next grid goes on
// meanwhile.
module grid_path_run_limited_dijkstra_core (
   input logic       clock,
   input logic       reset,
   grdp_req_if.sink  req_bus,
   grdp_rsp_if.source rsp_bus,
   grdp_csr_if.sink  csr_bus
);

   logic                            busy_ff;
   logic                            rsp_valid_ff;
   logic [grdp_pkg::COST_W-1:0]     min_cost_ff;
   logic                            reachable_ff;
   logic                            overflow_ff;
   logic [grdp_pkg::ROWC_W-1:0]     row_count_ff, row_count_in;
   logic [grdp_pkg::COLC_W-1:0]     load_col_ff, load_col_in;
   logic [grdp_pkg::CFG_W-1:0]      min_run_ff;
   logic [grdp_pkg::CFG_W-1:0]      max_run_ff;

   logic                            req_xfer;
   logic [grdp_pkg::ROWC_W-1:0]     row_next;
   logic [grdp_pkg::COLC_W-1:0]     col_next;
   grdp_pkg::cell_wr_type           cell_wr;
   grdp_pkg::srch_cmd_type          cmd;
   grdp_pkg::srch_res_type          res;

   assign req_bus.ready = !busy_ff;
   assign csr_bus.ready = 1'b1;
   assign req_xfer      = req_bus.valid && !busy_ff;

   assign col_next = (load_col_ff < grdp_pkg::COLC_W'(grdp_pkg::MAX_COLS))
                     ? load_col_ff + grdp_pkg::COLC_W'(1) : load_col_ff;
   assign row_next = (row_count_ff < grdp_pkg::ROWC_W'(grdp_pkg::MAX_ROWS))
                     ? row_count_ff + grdp_pkg::ROWC_W'(1) : row_count_ff;

   assign cell_wr.en   = req_xfer && (row_count_ff < grdp_pkg::ROWC_W'(grdp_pkg::MAX_ROWS))
                         && (load_col_ff < grdp_pkg::COLC_W'(grdp_pkg::MAX_COLS));
   assign cell_wr.addr = grdp_pkg::cell_addr(grdp_pkg::ROW_W'(row_count_ff),
                                             grdp_pkg::COL_W'(load_col_ff));
   assign cell_wr.cost = req_bus.cell_cost;

   assign cmd.start   = req_xfer && req_bus.grid_end;
   assign cmd.rows    = row_next;
   assign cmd.cols    = col_next;
   assign cmd.min_run = min_run_ff;
   assign cmd.max_run = (max_run_ff > grdp_pkg::RUN_TOP) ? grdp_pkg::RUN_TOP : max_run_ff;

   always_comb begin
      row_count_in = row_count_ff;
      load_col_in  = load_col_ff;
      if (req_xfer) begin
         load_col_in = col_next;
         if (req_bus.grid_end) begin
            row_count_in = '0;
            load_col_in  = '0;
         end else if (req_bus.row_end) begin
            row_count_in = row_next;
            load_col_in  = '0;
         end
      end
   end

   grdp_search u_search (
      .clock(clock), .reset(reset), .cell_wr(cell_wr), .cmd(cmd),
      .res_ready(!rsp_valid_ff), .res(res));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_count_ff <= '0;
         load_col_ff  <= '0;
         min_run_ff   <= grdp_pkg::MIN_RUN_RST;
         max_run_ff   <= grdp_pkg::MAX_RUN_RST;
      end else begin
         row_count_ff <= row_count_in;
         load_col_ff  <= load_col_in;
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (res.done) begin
            busy_ff <= 1'b0;
         end
         if (res.done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_bus.valid) begin
            if (csr_bus.index == grdp_pkg::CSR_MIN_RUN) begin
               min_run_ff <= csr_bus.data;
            end else if (csr_bus.index == grdp_pkg::CSR_MAX_RUN) begin
               max_run_ff <= csr_bus.data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res.done) begin
         min_cost_ff  <= res.min_cost;
         reachable_ff <= res.reachable;
         overflow_ff  <= res.overflow;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.min_cost       = min_cost_ff;
   assign rsp_bus.reachable      = reachable_ff;
   assign rsp_bus.queue_overflow = overflow_ff;

endmodule

/* design/grdp_checker.sv */
// Port-level checks for the grid path search core, bound to the top level.
// Depends on grdp_pkg and grid_path_run_limited_dijkstra_core.
module grdp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_grid_end,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [grdp_pkg::COST_W-1:0] rsp_min_cost,
   input logic                        rsp_reachable
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reachable |-> rsp_min_cost == '0)
      else $error("nonzero cost on unreachable result");

   a_search_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_grid_end |=> !req_ready)
      else $error("input taken while search runs");

endmodule

bind grid_path_run_limited_dijkstra_core grdp_checker u_grdp_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_bus.valid),
   .req_ready(req_bus.ready),
   .req_grid_end(req_bus.grid_end),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_min_cost(rsp_bus.min_cost),
   .rsp_reachable(rsp_bus.reachable)
);
